// ===== sv/x86d_pkg.sv =====
// ----------------------------------------------------------------------------
// x86d_pkg
// Shared types, decoder class codes and opcode classification functions.
// ----------------------------------------------------------------------------
package x86d_pkg;

  typedef enum logic [4:0] {
    F_RMREG   = 5'd0,
    F_IMMRM   = 5'd1,
    F_IMMACC  = 5'd2,
    F_MEMACC  = 5'd3,
    F_SINGLE  = 5'd4,
    F_XCHG    = 5'd5,
    F_MNEM    = 5'd6,
    F_PUSHPOP = 5'd7,
    F_JCC     = 5'd8,
    F_MOVIMM  = 5'd9,
    F_MOVSEG  = 5'd10,
    F_GROUP   = 5'd11,
    F_INOUT   = 5'd12,
    F_SHIFT   = 5'd13,
    F_REP     = 5'd14,
    F_ESC     = 5'd15,
    F_NEAR    = 5'd16,
    F_FAR     = 5'd17,
    F_BAD     = 5'd18,
    F_SEGPFX  = 5'd19,
    F_LOCKPFX = 5'd20
  } form_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_MODRM = 4'd1,
    PH_D0    = 4'd2,
    PH_D1    = 4'd3,
    PH_I0    = 4'd4,
    PH_I1    = 4'd5,
    PH_S0    = 4'd6,
    PH_S1    = 4'd7,
    PH_DONE  = 4'd8
  } phase_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD      = 2'd1;
  localparam logic [1:0] ST_NOMEMSEG = 2'd2;

  localparam logic [1:0] MK_NONE  = 2'd0;
  localparam logic [1:0] MK_MODRM = 2'd1;
  localparam logic [1:0] MK_PLAIN = 2'd2;

  // held instruction state passed from the sequencer to the record builder
  typedef struct packed {
    logic [3:0]  bytes_taken;
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [15:0] imm;
    logic [15:0] segword;
    logic [3:0]  prefix;
  } instr_t;

  typedef struct packed {
    logic [7:0]  opcode_byte;
    logic [4:0]  form;
    logic [3:0]  length;
    logic [7:0]  modrm_byte;
    logic        wide;
    logic        reg_is_dest;
    logic [15:0] displacement;
    logic [16:0] immediate;
    logic [15:0] far_segment;
    logic        lock_prefix;
    logic [2:0]  seg_override;
    logic [1:0]  status;
  } record_t;

  function automatic form_t form_of(input logic [7:0] op);
    form_t f;
    logic [2:0] lo;
    lo = op[2:0];
    f = F_BAD;
    if (op < 8'h40) begin
      if (lo < 3'd4) f = F_RMREG;
      else if (lo < 3'd6) f = F_IMMACC;
      else if (op[5]) f = (lo == 3'd6) ? F_SEGPFX : F_MNEM;
      else f = F_PUSHPOP;
    end else if (op < 8'h60) f = F_SINGLE;
    else if (op < 8'h70) f = F_BAD;
    else if (op < 8'h80) f = F_JCC;
    else if (op < 8'h84) f = F_IMMRM;
    else if (op == 8'h8c || op == 8'h8e) f = F_MOVSEG;
    else if (op == 8'h8f) f = F_GROUP;
    else if (op < 8'h90) f = F_RMREG;
    else if (op < 8'h98) f = F_XCHG;
    else if (op == 8'h9a) f = F_FAR;
    else if (op < 8'ha0) f = F_MNEM;
    else if (op < 8'ha4) f = F_MEMACC;
    else if (op == 8'ha8 || op == 8'ha9) f = F_IMMACC;
    else if (op < 8'hb0) f = F_MNEM;
    else if (op < 8'hc0) f = F_MOVIMM;
    else begin
      case (op) inside
        8'hc4, 8'hc5: f = F_RMREG;
        8'hc6, 8'hc7: f = F_IMMRM;
        8'hc2, 8'hc3, [8'hca:8'hcf], 8'hd4, 8'hd5, 8'hd7, 8'hf4, 8'hf5,
        [8'hf8:8'hfd]: f = F_MNEM;
        [8'hd0:8'hd3]: f = F_SHIFT;
        [8'hd8:8'hdf]: f = F_ESC;
        [8'he0:8'he3]: f = F_JCC;
        [8'he4:8'he7], [8'hec:8'hef]: f = F_INOUT;
        8'he8, 8'he9, 8'heb: f = F_NEAR;
        8'hea: f = F_FAR;
        8'hf0: f = F_LOCKPFX;
        8'hf2, 8'hf3: f = F_REP;
        8'hf6, 8'hf7, 8'hfe, 8'hff: f = F_GROUP;
        default: f = F_BAD;
      endcase
    end
    return f;
  endfunction

  function automatic logic [1:0] modrm_kind(input logic [7:0] op, input form_t f);
    logic [1:0] k;
    case (f)
      F_RMREG, F_IMMRM, F_MOVSEG, F_GROUP, F_SHIFT, F_ESC: k = MK_MODRM;
      F_REP: k = MK_PLAIN;
      default: k = (op == 8'hd4 || op == 8'hd5) ? MK_PLAIN : MK_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] disp_len(input logic [7:0] op, input form_t f,
                                          input logic [7:0] m);
    logic [1:0] d;
    d = 2'd0;
    if (f == F_MEMACC) d = 2'd2;
    else if (modrm_kind(op, f) == MK_MODRM) begin
      if (m[7:6] == 2'd0) d = (m[2:0] == 3'b110) ? 2'd2 : 2'd0;
      else if (m[7:6] == 2'd3) d = 2'd0;
      else d = m[7:6];
    end
    return d;
  endfunction

  function automatic logic [1:0] imm_len(input logic [7:0] op, input form_t f,
                                         input logic [7:0] m);
    logic [1:0] n;
    case (f)
      F_IMMRM: n = (op == 8'h81 || op == 8'hc7) ? 2'd2 : 2'd1;
      F_IMMACC: n = 2'd1 + {1'b0, op[0]};
      F_MOVIMM: n = 2'd1 + {1'b0, op[3]};
      F_GROUP: n = (op[7:1] == 7'b1111011 && m[5:3] == 3'd0) ?
                   2'd1 + {1'b0, op[0]} : 2'd0;
      F_MNEM: begin
        if (op == 8'hc2 || op == 8'hca) n = 2'd2;
        else n = (op == 8'hcd) ? 2'd1 : 2'd0;
      end
      F_JCC: n = 2'd1;
      F_NEAR: n = (op == 8'heb) ? 2'd1 : 2'd2;
      F_FAR: n = 2'd2;
      F_INOUT: n = op[3] ? 2'd0 : 2'd1;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/x86d_stream_if.sv =====
// ----------------------------------------------------------------------------
// x86d_stream_if
// Valid/ready channel carrying one payload of parameter type.
// ----------------------------------------------------------------------------
interface x86d_stream_if #(parameter type T = logic [7:0]);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/x86_16_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// x86_16_instruction_decoder
// 8086 machine code decoder, one code byte per request, one record per
// instruction.
// ----------------------------------------------------------------------------
// Usage:
//   code_in carries one code byte per request (valid/ready). rec_out carries
//   one decoded record for each completed instruction, including a record
//   for an unsupported opcode on its own byte.
//   Throughput: one byte per cycle while code_in.ready is high; the byte
//   sequencer updates its phase and held fields on each accepted byte.
//   The record is loaded into the output register when the last byte of
//   its instruction is accepted and appears there in the cycle after.
//   Reset clears the byte position, the phase and all held fields.
//   When the receiver stalls, the record waits in the output register; a
//   byte is still taken in that cycle unless it would complete another
//   record, in which case code_in.ready drops until the record is taken.
// ----------------------------------------------------------------------------
module x86_16_instruction_decoder #(
  parameter int POSITION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  x86d_stream_if.sink                           code_in,
  x86d_stream_if.source                         rec_out
);

  logic [POSITION_BITS-1:0] position;
  logic [POSITION_BITS-1:0] pos_inc;
  logic                     take, done, room;
  x86d_pkg::instr_t         din;
  x86d_pkg::record_t        rec, out_reg;
  logic                     out_valid;

  // accept while the output slot is free or the byte completes nothing
  assign room = !out_valid || rec_out.ready;
  assign code_in.ready = room || !done;
  assign take = code_in.valid && code_in.ready;
  assign pos_inc = position + POSITION_BITS'(1);

  x86d_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .code_byte  (code_in.data),
    .done       (done),
    .done_instr (din)
  );

  x86d_rec #(.POSITION_BITS(POSITION_BITS)) u_rec (
    .ins      (din),
    .position (pos_inc),
    .rec      (rec)
  );

  // byte position counter
  always_ff @(posedge clk) begin
    if (rst) position <= '0;
    else if (take) position <= pos_inc;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && done) begin
      out_valid <= 1'b1;
    end else if (rec_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && done) out_reg <= rec;
  end

  assign rec_out.valid = out_valid;
  assign rec_out.data = out_reg;

endmodule

// ===== sv/x86d_seq.sv =====
// ----------------------------------------------------------------------------
// x86d_seq
// Byte sequencer: collects prefixes and instruction bytes, flags completion.
// ----------------------------------------------------------------------------
module x86d_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          code_byte,
  output logic                done,
  output x86d_pkg::instr_t    done_instr
);

  x86d_pkg::phase_t phase, phase_next;
  x86d_pkg::phase_t ph_step;
  x86d_pkg::instr_t cur, cur_next;
  x86d_pkg::instr_t upd;
  x86d_pkg::form_t  f_in, f_h;
  logic             is_pfx;

  // first phase after p that this instruction needs
  function automatic x86d_pkg::phase_t next_ph(input x86d_pkg::phase_t p,
                                               input x86d_pkg::instr_t s);
    x86d_pkg::form_t f;
    logic [1:0] dl, il, mk;
    x86d_pkg::phase_t r;
    f = x86d_pkg::form_of(s.opcode);
    mk = x86d_pkg::modrm_kind(s.opcode, f);
    dl = x86d_pkg::disp_len(s.opcode, f, s.modrm);
    il = x86d_pkg::imm_len(s.opcode, f, s.modrm);
    r = x86d_pkg::PH_DONE;
    if (f == x86d_pkg::F_FAR && p < x86d_pkg::PH_S1) r = x86d_pkg::PH_S1;
    if (f == x86d_pkg::F_FAR && p < x86d_pkg::PH_S0) r = x86d_pkg::PH_S0;
    if (il >= 2'd2 && p < x86d_pkg::PH_I1) r = x86d_pkg::PH_I1;
    if (il >= 2'd1 && p < x86d_pkg::PH_I0) r = x86d_pkg::PH_I0;
    if (dl >= 2'd2 && p < x86d_pkg::PH_D1) r = x86d_pkg::PH_D1;
    if (dl >= 2'd1 && p < x86d_pkg::PH_D0) r = x86d_pkg::PH_D0;
    if (mk != x86d_pkg::MK_NONE && p < x86d_pkg::PH_MODRM) r = x86d_pkg::PH_MODRM;
    return r;
  endfunction

  // merge the new byte into the held instruction
  always_comb begin
    upd = cur;
    upd.bytes_taken = (cur.bytes_taken < 4'd15) ? cur.bytes_taken + 4'd1 : cur.bytes_taken;
    f_in = x86d_pkg::form_of(code_byte);
    is_pfx = 1'b0;
    case (phase)
      x86d_pkg::PH_IDLE: begin
        if (f_in == x86d_pkg::F_LOCKPFX) begin
          upd.prefix[3] = 1'b1;
          is_pfx = 1'b1;
        end else if (f_in == x86d_pkg::F_SEGPFX) begin
          upd.prefix[2:0] = {1'b0, code_byte[4:3]} + 3'd1;
          is_pfx = 1'b1;
        end else begin
          upd.opcode = code_byte;
        end
      end
      x86d_pkg::PH_MODRM: upd.modrm = code_byte;
      x86d_pkg::PH_D0: upd.disp[7:0] = code_byte;
      x86d_pkg::PH_D1: upd.disp[15:8] = code_byte;
      x86d_pkg::PH_I0: upd.imm[7:0] = code_byte;
      x86d_pkg::PH_I1: upd.imm[15:8] = code_byte;
      x86d_pkg::PH_S0: upd.segword[7:0] = code_byte;
      x86d_pkg::PH_S1: upd.segword[15:8] = code_byte;
      default: ;
    endcase
  end

  // next phase and completion; done tells whether the offered byte would
  // complete an instruction, the state only moves when the byte is taken
  always_comb begin
    f_h = x86d_pkg::form_of(upd.opcode);
    ph_step = next_ph(phase, upd);
    phase_next = phase;
    cur_next = cur;
    done = 1'b0;
    if (phase == x86d_pkg::PH_DONE) begin
      phase_next = x86d_pkg::PH_IDLE;
      cur_next = '0;
    end else if (is_pfx) begin
      cur_next = upd;
    end else if (phase == x86d_pkg::PH_IDLE && f_h == x86d_pkg::F_BAD) begin
      done = 1'b1;
      phase_next = x86d_pkg::PH_IDLE;
      cur_next = '0;
    end else if (ph_step == x86d_pkg::PH_DONE) begin
      done = 1'b1;
      phase_next = x86d_pkg::PH_IDLE;
      cur_next = '0;
    end else begin
      phase_next = ph_step;
      cur_next = upd;
    end
    if (!take) begin
      phase_next = phase;
      cur_next = cur;
    end
  end

  assign done_instr = upd;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= x86d_pkg::PH_IDLE;
      cur <= '0;
    end else begin
      phase <= phase_next;
      cur <= cur_next;
    end
  end

endmodule

// ===== sv/x86d_rec.sv =====
// ----------------------------------------------------------------------------
// x86d_rec
// Builds the decoded record from a complete instruction.
// ----------------------------------------------------------------------------
module x86d_rec #(
  parameter int POSITION_BITS = 16
) (
  input  x86d_pkg::instr_t        ins,
  input  logic [POSITION_BITS-1:0] position,
  output x86d_pkg::record_t       rec
);

  localparam int PW = (POSITION_BITS < 16) ? POSITION_BITS : 16;

  x86d_pkg::form_t f;
  logic [1:0]  mk, dl, il;
  logic [7:0]  op, m;
  logic [16:0] imm;
  logic [15:0] disp;
  logic        sgn, mem;
  logic [15:0] tgt;

  always_comb begin
    op = ins.opcode;
    m = ins.modrm;
    f = x86d_pkg::form_of(op);
    mk = x86d_pkg::modrm_kind(op, f);
    dl = x86d_pkg::disp_len(op, f, m);
    il = x86d_pkg::imm_len(op, f, m);
    rec = '0;
    rec.opcode_byte = op;
    rec.length = (ins.bytes_taken > 4'd8) ? 4'd8 : ins.bytes_taken;
    rec.lock_prefix = ins.prefix[3];
    rec.seg_override = ins.prefix[2:0];
    tgt = '0;
    mem = 1'b0;

    // displacement, sign extended
    disp = '0;
    if (dl == 2'd1) disp = {{8{ins.disp[7]}}, ins.disp[7:0]};
    else if (dl == 2'd2) disp = ins.disp;

    // immediate with opcode-specific signedness
    if (f == x86d_pkg::F_IMMRM) sgn = op[1];
    else sgn = (f == x86d_pkg::F_IMMACC || f == x86d_pkg::F_MOVIMM ||
                f == x86d_pkg::F_GROUP || f == x86d_pkg::F_FAR ||
                f == x86d_pkg::F_JCC || f == x86d_pkg::F_NEAR);
    imm = '0;
    if (il == 2'd1) imm = {{9{sgn & ins.imm[7]}}, ins.imm[7:0]};
    else if (il == 2'd2) imm = {sgn & ins.imm[15], ins.imm};

    // resolved jump target and special immediates
    if (f == x86d_pkg::F_JCC || f == x86d_pkg::F_NEAR) begin
      tgt = 16'(32'(position) + 32'(imm[15:0]));
      imm = '0;
      imm[PW-1:0] = tgt[PW-1:0];
    end else if (f == x86d_pkg::F_SHIFT) imm = op[1] ? 17'd0 : 17'd1;
    else if (f == x86d_pkg::F_ESC) imm = {11'd0, op[2:0], m[5:3]};

    if (f == x86d_pkg::F_BAD) begin
      rec.form = x86d_pkg::F_BAD;
      rec.status = x86d_pkg::ST_BAD;
    end else begin
      rec.form = f;
      case (f)
        x86d_pkg::F_RMREG: begin
          rec.wide = (op == 8'hc4 || op == 8'hc5) ? 1'b1 : op[0];
          rec.reg_is_dest = (op == 8'h8d || op == 8'hc4 || op == 8'hc5) ? 1'b1 : op[1];
        end
        x86d_pkg::F_IMMACC, x86d_pkg::F_MEMACC, x86d_pkg::F_INOUT: begin
          rec.wide = op[0];
          rec.reg_is_dest = ~op[1];
        end
        x86d_pkg::F_IMMRM, x86d_pkg::F_GROUP, x86d_pkg::F_SHIFT: rec.wide = op[0];
        x86d_pkg::F_MOVIMM: begin
          rec.wide = op[3];
          rec.reg_is_dest = 1'b1;
        end
        x86d_pkg::F_MOVSEG: begin
          rec.wide = 1'b1;
          rec.reg_is_dest = op[1];
        end
        x86d_pkg::F_SINGLE, x86d_pkg::F_XCHG, x86d_pkg::F_PUSHPOP, x86d_pkg::F_ESC,
        x86d_pkg::F_FAR: rec.wide = 1'b1;
        x86d_pkg::F_NEAR: rec.wide = (op != 8'heb);
        x86d_pkg::F_REP: rec.wide = m[0];
        x86d_pkg::F_MNEM: begin
          if (op >= 8'ha4 && op <= 8'haf) rec.wide = op[0];
          else if (op == 8'hc2 || op == 8'hca) rec.wide = 1'b1;
        end
        default: ;
      endcase
      mem = (f == x86d_pkg::F_MEMACC) || (mk == x86d_pkg::MK_MODRM && m[7:6] != 2'd3);
      rec.status = (ins.prefix[2:0] != 3'd0 && !mem) ? x86d_pkg::ST_NOMEMSEG
                                                     : x86d_pkg::ST_OK;
      rec.modrm_byte = (mk != x86d_pkg::MK_NONE) ? m : 8'd0;
      rec.displacement = disp;
      rec.immediate = imm;
      rec.far_segment = (f == x86d_pkg::F_FAR) ? ins.segword : 16'd0;
    end
  end

endmodule

// ===== test/x86_16_instruction_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// x86_16_instruction_decoder_tb
// Feeds 8086 code bytes through the decoder and checks every decoded record
// against a byte-level decode model kept in the bench, with bursty requests
// on the input side and a stalling receiver on the record side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module x86_16_instruction_decoder_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 10;
  localparam int RANDOM_BYTES   = 1350;

  logic clk;
  logic rst;

  x86d_stream_if #(.T(logic [7:0]))          code_if ();
  x86d_stream_if #(.T(x86d_pkg::record_t))   rec_if ();

  x86_16_instruction_decoder #(.POSITION_BITS(16)) uut (
    .clk     (clk),
    .rst     (rst),
    .code_in (code_if.sink),
    .rec_out (rec_if.source)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  logic [7:0]        code_q[$];
  x86d_pkg::record_t pending_records[$];
  int                fails;
  int                idle_cycles;
  int                queued;
  bit                stim_done;

  // decode model state
  logic [15:0] dec_pos;
  int          dec_phase;
  logic [3:0]  dec_taken;
  logic [7:0]  dec_op;
  logic [7:0]  dec_modrm;
  logic [15:0] dec_disp;
  logic [15:0] dec_imm;
  logic [15:0] dec_seg;
  logic [3:0]  dec_pfx;

  // opcode class
  function automatic x86d_pkg::form_t op_class(input logic [7:0] op);
    if (op < 8'h40) begin
      if (op[2:0] < 3'd4) return x86d_pkg::F_RMREG;
      if (op[2:0] < 3'd6) return x86d_pkg::F_IMMACC;
      if (op[5]) return (op[2:0] == 3'd6) ? x86d_pkg::F_SEGPFX : x86d_pkg::F_MNEM;
      return x86d_pkg::F_PUSHPOP;
    end
    if (op < 8'h60) return x86d_pkg::F_SINGLE;
    if (op < 8'h70) return x86d_pkg::F_BAD;
    if (op < 8'h80) return x86d_pkg::F_JCC;
    if (op < 8'h84) return x86d_pkg::F_IMMRM;
    if (op == 8'h8c || op == 8'h8e) return x86d_pkg::F_MOVSEG;
    if (op == 8'h8f) return x86d_pkg::F_GROUP;
    if (op < 8'h90) return x86d_pkg::F_RMREG;
    if (op < 8'h98) return x86d_pkg::F_XCHG;
    if (op == 8'h9a) return x86d_pkg::F_FAR;
    if (op < 8'ha0) return x86d_pkg::F_MNEM;
    if (op < 8'ha4) return x86d_pkg::F_MEMACC;
    if (op == 8'ha8 || op == 8'ha9) return x86d_pkg::F_IMMACC;
    if (op < 8'hb0) return x86d_pkg::F_MNEM;
    if (op < 8'hc0) return x86d_pkg::F_MOVIMM;
    if (op == 8'hc4 || op == 8'hc5) return x86d_pkg::F_RMREG;
    if (op == 8'hc6 || op == 8'hc7) return x86d_pkg::F_IMMRM;
    if (op == 8'hc2 || op == 8'hc3 || (op >= 8'hca && op <= 8'hcf) || op == 8'hd4 ||
        op == 8'hd5 || op == 8'hd7 || op == 8'hf4 || op == 8'hf5 ||
        (op >= 8'hf8 && op <= 8'hfd)) return x86d_pkg::F_MNEM;
    if (op >= 8'hd0 && op <= 8'hd3) return x86d_pkg::F_SHIFT;
    if (op >= 8'hd8 && op <= 8'hdf) return x86d_pkg::F_ESC;
    if (op >= 8'he0 && op <= 8'he3) return x86d_pkg::F_JCC;
    if ((op >= 8'he4 && op <= 8'he7) || op >= 8'hec && op <= 8'hef)
      return x86d_pkg::F_INOUT;
    if (op == 8'he8 || op == 8'he9 || op == 8'heb) return x86d_pkg::F_NEAR;
    if (op == 8'hea) return x86d_pkg::F_FAR;
    if (op == 8'hf0) return x86d_pkg::F_LOCKPFX;
    if (op == 8'hf2 || op == 8'hf3) return x86d_pkg::F_REP;
    if (op == 8'hf6 || op == 8'hf7 || op == 8'hfe || op == 8'hff) return x86d_pkg::F_GROUP;
    return x86d_pkg::F_BAD;
  endfunction

  // second byte kind: true modrm or plain byte
  function automatic logic [1:0] second_kind(input logic [7:0] op,
                                             input x86d_pkg::form_t f);
    if (f inside {x86d_pkg::F_RMREG, x86d_pkg::F_IMMRM, x86d_pkg::F_MOVSEG,
                  x86d_pkg::F_GROUP, x86d_pkg::F_SHIFT, x86d_pkg::F_ESC})
      return x86d_pkg::MK_MODRM;
    if (f == x86d_pkg::F_REP || op == 8'hd4 || op == 8'hd5) return x86d_pkg::MK_PLAIN;
    return x86d_pkg::MK_NONE;
  endfunction

  function automatic int disp_bytes(input logic [7:0] op, input x86d_pkg::form_t f,
                                    input logic [7:0] m);
    if (f == x86d_pkg::F_MEMACC) return 2;
    if (second_kind(op, f) != x86d_pkg::MK_MODRM) return 0;
    if (m[7:6] == 2'd0) return (m[2:0] == 3'd6) ? 2 : 0;
    if (m[7:6] == 2'd3) return 0;
    return int'(m[7:6]);
  endfunction

  function automatic int imm_bytes(input logic [7:0] op, input x86d_pkg::form_t f,
                                   input logic [7:0] m);
    case (f)
      x86d_pkg::F_IMMRM:  return (op == 8'h81 || op == 8'hc7) ? 2 : 1;
      x86d_pkg::F_IMMACC: return 1 + int'(op[0]);
      x86d_pkg::F_MOVIMM: return 1 + int'(op[3]);
      x86d_pkg::F_GROUP:
        return ((op == 8'hf6 || op == 8'hf7) && m[5:3] == 3'd0) ? 1 + int'(op[0]) : 0;
      x86d_pkg::F_MNEM:   return (op == 8'hc2 || op == 8'hca) ? 2 : (op == 8'hcd ? 1 : 0);
      x86d_pkg::F_JCC:    return 1;
      x86d_pkg::F_NEAR:   return (op == 8'heb) ? 1 : 2;
      x86d_pkg::F_FAR:    return 2;
      x86d_pkg::F_INOUT:  return op[3] ? 0 : 1;
      default:            return 0;
    endcase
  endfunction

  function automatic bit phase_wanted(input int p);
    x86d_pkg::form_t f;
    f = op_class(dec_op);
    case (p)
      x86d_pkg::PH_MODRM: return second_kind(dec_op, f) != x86d_pkg::MK_NONE;
      x86d_pkg::PH_D0:    return disp_bytes(dec_op, f, dec_modrm) >= 1;
      x86d_pkg::PH_D1:    return disp_bytes(dec_op, f, dec_modrm) >= 2;
      x86d_pkg::PH_I0:    return imm_bytes(dec_op, f, dec_modrm) >= 1;
      x86d_pkg::PH_I1:    return imm_bytes(dec_op, f, dec_modrm) >= 2;
      x86d_pkg::PH_S0, x86d_pkg::PH_S1: return f == x86d_pkg::F_FAR;
      default:            return 1'b0;
    endcase
  endfunction

  function automatic void clear_held();
    dec_phase = x86d_pkg::PH_IDLE;
    dec_taken = '0;
    dec_op    = '0;
    dec_modrm = '0;
    dec_disp  = '0;
    dec_imm   = '0;
    dec_seg   = '0;
    dec_pfx   = '0;
  endfunction

  // build the record of the held instruction
  function automatic x86d_pkg::record_t build_record();
    x86d_pkg::record_t r;
    x86d_pkg::form_t f;
    logic [1:0] mk;
    int dl, il;
    logic [16:0] iv;
    logic [15:0] tgt;
    bit sgn, mem;
    f = op_class(dec_op);
    r = '0;
    r.opcode_byte  = dec_op;
    r.length       = (dec_taken > 4'd8) ? 4'd8 : dec_taken;
    r.lock_prefix  = dec_pfx[3];
    r.seg_override = dec_pfx[2:0];
    r.form         = f;
    if (f == x86d_pkg::F_BAD) begin
      r.status = x86d_pkg::ST_BAD;
      return r;
    end
    mk = second_kind(dec_op, f);
    dl = disp_bytes(dec_op, f, dec_modrm);
    il = imm_bytes(dec_op, f, dec_modrm);
    if (dl == 1) r.displacement = {{8{dec_disp[7]}}, dec_disp[7:0]};
    else if (dl == 2) r.displacement = dec_disp;
    sgn = (f == x86d_pkg::F_IMMRM) ? dec_op[1] :
          (f inside {x86d_pkg::F_IMMACC, x86d_pkg::F_MOVIMM, x86d_pkg::F_GROUP,
                     x86d_pkg::F_FAR, x86d_pkg::F_JCC, x86d_pkg::F_NEAR});
    iv = '0;
    if (il == 1) iv = sgn ? {{9{dec_imm[7]}}, dec_imm[7:0]} : {9'd0, dec_imm[7:0]};
    else if (il == 2) iv = sgn ? {dec_imm[15], dec_imm} : {1'b0, dec_imm};
    if (f == x86d_pkg::F_JCC || f == x86d_pkg::F_NEAR) begin
      tgt = dec_pos + iv[15:0];
      iv = {1'b0, tgt};
    end else if (f == x86d_pkg::F_SHIFT) iv = dec_op[1] ? 17'd0 : 17'd1;
    else if (f == x86d_pkg::F_ESC) iv = {11'd0, dec_op[2:0], dec_modrm[5:3]};
    r.immediate = iv;
    if (f == x86d_pkg::F_FAR) r.far_segment = dec_seg;
    case (f)
      x86d_pkg::F_RMREG: begin
        r.wide = (dec_op == 8'hc4 || dec_op == 8'hc5) ? 1'b1 : dec_op[0];
        r.reg_is_dest = (dec_op == 8'h8d || dec_op == 8'hc4 || dec_op == 8'hc5) ?
                        1'b1 : dec_op[1];
      end
      x86d_pkg::F_IMMACC, x86d_pkg::F_MEMACC, x86d_pkg::F_INOUT: begin
        r.wide = dec_op[0];
        r.reg_is_dest = ~dec_op[1];
      end
      x86d_pkg::F_IMMRM, x86d_pkg::F_GROUP, x86d_pkg::F_SHIFT: r.wide = dec_op[0];
      x86d_pkg::F_MOVIMM: begin
        r.wide = dec_op[3];
        r.reg_is_dest = 1'b1;
      end
      x86d_pkg::F_MOVSEG: begin
        r.wide = 1'b1;
        r.reg_is_dest = dec_op[1];
      end
      x86d_pkg::F_SINGLE, x86d_pkg::F_XCHG, x86d_pkg::F_PUSHPOP, x86d_pkg::F_ESC,
      x86d_pkg::F_FAR: r.wide = 1'b1;
      x86d_pkg::F_NEAR: r.wide = (dec_op != 8'heb);
      x86d_pkg::F_REP: r.wide = dec_modrm[0];
      x86d_pkg::F_MNEM: begin
        if (dec_op >= 8'ha4 && dec_op <= 8'haf) r.wide = dec_op[0];
        else if (dec_op == 8'hc2 || dec_op == 8'hca) r.wide = 1'b1;
      end
      default: ;
    endcase
    mem = (f == x86d_pkg::F_MEMACC) ||
          (mk == x86d_pkg::MK_MODRM && dec_modrm[7:6] != 2'd3);
    r.modrm_byte = (mk != x86d_pkg::MK_NONE) ? dec_modrm : 8'd0;
    r.status = (dec_pfx[2:0] != 3'd0 && !mem) ? x86d_pkg::ST_NOMEMSEG : x86d_pkg::ST_OK;
    return r;
  endfunction

  // advance the decode model by one accepted byte
  task automatic decode_byte(input logic [7:0] b);
    x86d_pkg::form_t f;
    int p;
    dec_pos = dec_pos + 16'd1;
    if (dec_taken < 4'd15) dec_taken = dec_taken + 4'd1;
    case (dec_phase)
      x86d_pkg::PH_IDLE: begin
        f = op_class(b);
        if (f == x86d_pkg::F_LOCKPFX) begin
          dec_pfx[3] = 1'b1;
          return;
        end
        if (f == x86d_pkg::F_SEGPFX) begin
          dec_pfx[2:0] = {1'b0, b[4:3]} + 3'd1;
          return;
        end
        dec_op = b;
        if (f == x86d_pkg::F_BAD) begin
          pending_records.insert(pending_records.size(), build_record());
          clear_held();
          return;
        end
      end
      x86d_pkg::PH_MODRM: dec_modrm = b;
      x86d_pkg::PH_D0:    dec_disp[7:0] = b;
      x86d_pkg::PH_D1:    dec_disp[15:8] = b;
      x86d_pkg::PH_I0:    dec_imm[7:0] = b;
      x86d_pkg::PH_I1:    dec_imm[15:8] = b;
      x86d_pkg::PH_S0:    dec_seg[7:0] = b;
      x86d_pkg::PH_S1:    dec_seg[15:8] = b;
      default: begin
        clear_held();
        return;
      end
    endcase
    p = dec_phase + 1;
    while (p < x86d_pkg::PH_DONE && !phase_wanted(p)) p++;
    if (p == x86d_pkg::PH_DONE) begin
      pending_records.insert(pending_records.size(), build_record());
      clear_held();
    end else dec_phase = p;
  endtask

  // request driver: bursts and gaps
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      code_if.valid <= 1'b0;
      code_if.data  <= 8'd0;
      burst_left = $urandom_range(1, 30);
      gap_left   = 0;
    end else if (!code_if.valid || code_if.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        code_if.valid <= 1'b0;
      end else if (code_q.size() > 0) begin
        code_if.data  <= code_q.pop_front();
        code_if.valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else code_if.valid <= 1'b0;
    end
  end

  // receiver stall pattern: rx_mode is redrawn at random from four modes
  int rx_cycle;
  int rx_mode;
  always @(posedge clk) begin
    if (rst) begin
      rec_if.ready <= 1'b0;
      rx_cycle = 0;
      rx_mode  = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: rec_if.ready <= 1'b1;
        1: rec_if.ready <= ($urandom_range(0, 9) < 7);
        2: rec_if.ready <= (rx_cycle % 11) > 3;
        default: rec_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [16:0] exp_v,
                             input logic [16:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  // monitor: model update on accepted bytes, record compare, watchdog
  always @(posedge clk) begin
    x86d_pkg::record_t exp_r, act_r;
    if (rst) begin
      dec_pos = '0;
      clear_held();
      idle_cycles = 0;
    end else begin
      if (code_if.valid && code_if.ready) decode_byte(code_if.data);
      if (rec_if.valid && rec_if.ready) begin
        act_r = rec_if.data;
        if (pending_records.size() == 0) begin
          $display("%0t: record with no request behind it: expected none actual %0h",
                   $time, act_r);
          fails++;
        end else begin
          exp_r = pending_records.pop_front();
          check_field("opcode_byte", 17'(exp_r.opcode_byte), 17'(act_r.opcode_byte));
          check_field("form", 17'(exp_r.form), 17'(act_r.form));
          check_field("length", 17'(exp_r.length), 17'(act_r.length));
          check_field("modrm_byte", 17'(exp_r.modrm_byte), 17'(act_r.modrm_byte));
          check_field("wide", 17'(exp_r.wide), 17'(act_r.wide));
          check_field("reg_is_dest", 17'(exp_r.reg_is_dest), 17'(act_r.reg_is_dest));
          check_field("displacement", 17'(exp_r.displacement), 17'(act_r.displacement));
          check_field("immediate", exp_r.immediate, act_r.immediate);
          check_field("far_segment", 17'(exp_r.far_segment), 17'(act_r.far_segment));
          check_field("lock_prefix", 17'(exp_r.lock_prefix), 17'(act_r.lock_prefix));
          check_field("seg_override", 17'(exp_r.seg_override), 17'(act_r.seg_override));
          check_field("status", 17'(exp_r.status), 17'(act_r.status));
        end
      end
      if ((code_if.valid && code_if.ready) || (rec_if.valid && rec_if.ready) ||
          stim_done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("x86_16_instruction_decoder_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic put(input logic [7:0] b);
    code_q.insert(code_q.size(), b);
    queued++;
  endtask

  // one well-formed instruction with random content
  task automatic put_instr();
    logic [7:0] op, m;
    x86d_pkg::form_t f;
    int npfx, k;
    npfx = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if ($urandom_range(0, 40) == 0) npfx = $urandom_range(5, 9);
    for (k = 0; k < npfx; k++) begin
      case ($urandom_range(0, 4))
        0: put(8'hf0);
        1: put(8'h26);
        2: put(8'h2e);
        3: put(8'h36);
        default: put(8'h3e);
      endcase
    end
    do begin
      op = 8'($urandom_range(0, 255));
      f = op_class(op);
    end while (f == x86d_pkg::F_LOCKPFX || f == x86d_pkg::F_SEGPFX);
    put(op);
    if (f == x86d_pkg::F_BAD) return;
    m = 8'($urandom_range(0, 255));
    if (second_kind(op, f) != x86d_pkg::MK_NONE) put(m);
    for (k = 0; k < disp_bytes(op, f, m) + imm_bytes(op, f, m); k++)
      put(8'($urandom_range(0, 255)));
    if (f == x86d_pkg::F_FAR) begin
      put(8'($urandom_range(0, 255)));
      put(8'($urandom_range(0, 255)));
    end
  endtask

  // stimulus and end of run
  initial begin
    int k;
    queued = 0;
    stim_done = 1'b0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: register forms, direct address, displacements, immediates
    put(8'h00); put(8'hc0);
    put(8'h8b); put(8'h06); put(8'h34); put(8'h12);
    put(8'h80); put(8'h40); put(8'hff); put(8'h7f);
    put(8'hc7); put(8'h80); put(8'h00); put(8'h80); put(8'hff); put(8'hff);
    put(8'h83); put(8'hc0); put(8'h80);
    // override without memory operand, then with direct address
    put(8'h26); put(8'h8b); put(8'hc0);
    put(8'h2e); put(8'ha1); put(8'hcd); put(8'hab);
    // lock and rep with string op
    put(8'hf0); put(8'hf3); put(8'ha5);
    put(8'h3e); put(8'hf2); put(8'ha4);
    // short jumps backward and forward, near jump and call, far call and jump
    put(8'heb); put(8'h80);
    put(8'h74); put(8'h7f);
    put(8'he9); put(8'hff); put(8'h7f);
    put(8'he8); put(8'h00); put(8'h80);
    put(8'h9a); put(8'h11); put(8'h22); put(8'h33); put(8'h44);
    put(8'hea); put(8'hff); put(8'hff); put(8'h00); put(8'h80);
    // shifts by one and by cl, escape, aam, int, ret with pop count
    put(8'hd1); put(8'he0);
    put(8'hd2); put(8'h28);
    put(8'hdf); put(8'hf8);
    put(8'hd4); put(8'h0a);
    put(8'hcd); put(8'hff);
    put(8'hc2); put(8'hff); put(8'hff);
    // test with immediate, group op without, mov immediate, an unsupported opcode
    put(8'hf7); put(8'h00); put(8'h55); put(8'haa);
    put(8'hf6); put(8'h10);
    put(8'hbf); put(8'h00); put(8'h80);
    put(8'h36); put(8'h60);
    put(8'hff);  put(8'h3f); put(8'h06); put(8'h00); put(8'h00);
    // repeated segment prefixes: last wins, length saturates
    for (k = 0; k < 8; k++) put(8'h26);
    put(8'h3e); put(8'h8b); put(8'h00);

    // random: mostly well-formed instructions, some raw noise
    while (queued < RANDOM_BYTES) begin
      if ($urandom_range(0, 15) == 0) put(8'($urandom_range(0, 255)));
      else put_instr();
      if (code_q.size() > 200) wait (code_q.size() < 100);
    end

    wait (code_q.size() == 0);
    @(posedge clk);
    while (code_if.valid) @(posedge clk);
    stim_done = 1'b1;
    k = 0;
    while (pending_records.size() > 0 && k < WATCHDOG_LIMIT) begin
      @(posedge clk);
      k++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0 && pending_records.size() == 0) begin
      $display("x86_16_instruction_decoder_tb: PASS");
    end else begin
      $display("x86_16_instruction_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule
